[hw/rtl/gtp_pkg.sv]
// gtp_pkg: constants, types and the cordic angle table for the go-to-pose controller
// used by gtp_cordic and go_to_pose_velocity_controller; no dependencies
`default_nettype none
package gtp_pkg;
	localparam int CordicStages = 16;
	localparam int CW = 44;                 // cordic x/y width
	localparam int ZW = 24;                 // cordic angle width, q.20
	localparam logic signed [ZW-1:0] PiQ20 = 24'sd3294199;
	localparam logic signed [16:0] PiQ12 = 17'sd12868;
	localparam logic signed [16:0] TwoPiQ12 = 17'sd25736;
	localparam logic [31:0] InvGainQ32 = 32'd2608131496;

	localparam logic [1:0] ModeTurnPoint = 2'd0;
	localparam logic [1:0] ModeDrive = 2'd1;
	localparam logic [1:0] ModeTurnHead = 2'd2;
	localparam logic [1:0] ModeStop = 2'd3;

	localparam logic [2:0] RegHeadGain = 3'd0;
	localparam logic [2:0] RegDistGain = 3'd1;
	localparam logic [2:0] RegBearGain = 3'd2;
	localparam logic [2:0] RegArrive = 3'd3;
	localparam logic [2:0] RegAngTol = 3'd4;
	localparam logic [2:0] RegMinTurn = 3'd5;
	localparam logic [2:0] RegMaxTurn = 3'd6;

	// side data that rides along with the cordic
	typedef struct packed {
		logic        zero;
		logic signed [16:0] e_head;
		logic signed [14:0] ryaw;
	} side_t;

	function automatic logic signed [ZW-1:0] atan_q20(input int i);
		case (i)
			0: atan_q20 = 24'sd823550;
			1: atan_q20 = 24'sd486170;
			2: atan_q20 = 24'sd256879;
			3: atan_q20 = 24'sd130396;
			4: atan_q20 = 24'sd65451;
			5: atan_q20 = 24'sd32757;
			6: atan_q20 = 24'sd16383;
			7: atan_q20 = 24'sd8192;
			8: atan_q20 = 24'sd4096;
			9: atan_q20 = 24'sd2048;
			10: atan_q20 = 24'sd1024;
			11: atan_q20 = 24'sd512;
			12: atan_q20 = 24'sd256;
			13: atan_q20 = 24'sd128;
			14: atan_q20 = 24'sd64;
			15: atan_q20 = 24'sd32;
			16: atan_q20 = 24'sd16;
			17: atan_q20 = 24'sd8;
			18: atan_q20 = 24'sd4;
			19: atan_q20 = 24'sd2;
			20: atan_q20 = 24'sd1;
			default: atan_q20 = '0;
		endcase
	endfunction
endpackage
`default_nettype wire

[hw/rtl/gtp_cordic.sv]
// gtp_cordic: pipelined vectoring cordic, one rotation per stage, with side data
// depends on gtp_pkg
`default_nettype none
module gtp_cordic (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             in_valid,
	input  wire logic signed [gtp_pkg::CW-1:0]    in_x,
	input  wire logic signed [gtp_pkg::CW-1:0]    in_y,
	input  wire logic signed [gtp_pkg::ZW-1:0]    in_z,
	input  wire gtp_pkg::side_t                   in_side,
	output logic                                  out_valid,
	output logic signed [gtp_pkg::CW-1:0]         out_x,
	output logic signed [gtp_pkg::ZW-1:0]         out_z,
	output gtp_pkg::side_t                        out_side
);
	localparam int N = gtp_pkg::CordicStages;
	logic                           v_s [0:N];
	logic signed [gtp_pkg::CW-1:0]  x_s [0:N];
	logic signed [gtp_pkg::CW-1:0]  y_s [0:N];
	logic signed [gtp_pkg::ZW-1:0]  z_s [0:N];
	gtp_pkg::side_t                 sd_s [0:N];

	assign v_s[0] = in_valid;
	assign x_s[0] = in_x;
	assign y_s[0] = in_y;
	assign z_s[0] = in_z;
	assign sd_s[0] = in_side;

	for (genvar i = 0; i < N; i++) begin : g_stage
		// valid bit of stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else if (en) v_s[i+1] <= v_s[i];
		end
		// one micro-rotation
		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[i+1] <= sd_s[i];
				if (!y_s[i][gtp_pkg::CW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + gtp_pkg::atan_q20(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - gtp_pkg::atan_q20(i);
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_x = x_s[N];
	assign out_z = z_s[N];
	assign out_side = sd_s[N];
endmodule
`default_nettype wire

[hw/rtl/go_to_pose_velocity_controller.sv]
// go_to_pose_velocity_controller: pipelined go-to-pose proportional controller
// depends on gtp_pkg and gtp_cordic
//
// channel  | dir | content
// s_axis   | in  | pose pair word
// m_axis   | out | speed, turn rate, mode word
// apb      | in  | seven control registers at 4*i
//
// one word per cycle sustained while the output is taken; the
// cordic pipeline sets the depth. the whole pipeline advances together and
// holds when the output register is full and not taken. reset clears valid
// bits and loads register defaults.
`default_nettype none
module go_to_pose_velocity_controller (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// robot_x[31:0] robot_y[63:32] robot_yaw[78:64] target_x[110:79]
	// target_y[142:111] target_yaw[157:143], zero pad to 160
	input  wire logic [159:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// linear_speed[30:0] turn_rate[44:31] mode[46:45], zero pad to 48
	output logic [47:0]       m_axis_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	localparam int CW = gtp_pkg::CW;
	localparam int ZW = gtp_pkg::ZW;

	// control registers
	logic [15:0] head_gain_q, dist_gain_q, bear_gain_q;
	logic [30:0] arrive_q;
	logic [14:0] tol_q, min_turn_q, max_turn_q;
	logic [2:0]  reg_idx;
	assign reg_idx = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_gain_q <= 16'd2048;
			dist_gain_q <= 16'd410;
			bear_gain_q <= 16'd2048;
			arrive_q <= 31'd22938;
			tol_q <= 15'd819;
			min_turn_q <= 15'd2458;
			max_turn_q <= 15'd4915;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (reg_idx)
				gtp_pkg::RegHeadGain: head_gain_q <= pwdata[15:0];
				gtp_pkg::RegDistGain: dist_gain_q <= pwdata[15:0];
				gtp_pkg::RegBearGain: bear_gain_q <= pwdata[15:0];
				gtp_pkg::RegArrive: arrive_q <= pwdata[30:0];
				gtp_pkg::RegAngTol: tol_q <= pwdata[14:0];
				gtp_pkg::RegMinTurn: min_turn_q <= pwdata[14:0];
				gtp_pkg::RegMaxTurn: max_turn_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		case (reg_idx)
			gtp_pkg::RegHeadGain: prdata = {16'd0, head_gain_q};
			gtp_pkg::RegDistGain: prdata = {16'd0, dist_gain_q};
			gtp_pkg::RegBearGain: prdata = {16'd0, bear_gain_q};
			gtp_pkg::RegArrive: prdata = {1'b0, arrive_q};
			gtp_pkg::RegAngTol: prdata = {17'd0, tol_q};
			gtp_pkg::RegMinTurn: prdata = {17'd0, min_turn_q};
			gtp_pkg::RegMaxTurn: prdata = {17'd0, max_turn_q};
			default: prdata = '0;
		endcase
	end

	// global pipeline enable: advance unless the output word is stuck
	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic signed [31:0] rx, ry, tx, ty;
	logic signed [14:0] ryaw, tyaw;
	assign rx = s_axis_tdata[31:0];
	assign ry = s_axis_tdata[63:32];
	assign ryaw = s_axis_tdata[78:64];
	assign tx = s_axis_tdata[110:79];
	assign ty = s_axis_tdata[142:111];
	assign tyaw = s_axis_tdata[157:143];

	// stage 1: differences and heading error
	logic               v_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [16:0] eh_s1;
	logic signed [14:0] ryaw_s1;
	logic signed [16:0] eh_raw;
	assign eh_raw = 17'(tyaw) - 17'(ryaw);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 33'(tx) - 33'(rx);
			dy_s1 <= 33'(ty) - 33'(ry);
			ryaw_s1 <= ryaw;
			if (eh_raw > gtp_pkg::PiQ12) eh_s1 <= eh_raw - gtp_pkg::TwoPiQ12;
			else if (eh_raw < -gtp_pkg::PiQ12) eh_s1 <= eh_raw + gtp_pkg::TwoPiQ12;
			else eh_s1 <= eh_raw;
		end
	end

	// stage 2: pre-rotation by pi into the right half plane
	logic               v_s2;
	logic signed [CW-1:0] x_s2, y_s2;
	logic signed [ZW-1:0] z_s2;
	gtp_pkg::side_t     sd_s2;
	logic signed [CW-1:0] x0, y0;
	assign x0 = {{(CW-41){dx_s1[32]}}, dx_s1, 8'd0};
	assign y0 = {{(CW-41){dy_s1[32]}}, dy_s1, 8'd0};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2.zero <= (dx_s1 == '0) && (dy_s1 == '0);
			sd_s2.e_head <= eh_s1;
			sd_s2.ryaw <= ryaw_s1;
			if (dx_s1[32]) begin
				x_s2 <= -x0;
				y_s2 <= -y0;
				z_s2 <= dy_s1[32] ? -gtp_pkg::PiQ20 : gtp_pkg::PiQ20;
			end else begin
				x_s2 <= x0;
				y_s2 <= y0;
				z_s2 <= '0;
			end
		end
	end

	logic                 v_c;
	logic signed [CW-1:0] x_c;
	logic signed [ZW-1:0] z_c;
	gtp_pkg::side_t       sd_c;
	gtp_cordic u_cordic (
		.clk, .arst_n, .en,
		.in_valid(v_s2), .in_x(x_s2), .in_y(y_s2), .in_z(z_s2), .in_side(sd_s2),
		.out_valid(v_c), .out_x(x_c), .out_z(z_c), .out_side(sd_c)
	);

	// stage 3: bearing rounding, bearing error, gain multiply of magnitude
	logic               v_s3;
	logic [63:0]        mag_s3;
	logic signed [16:0] eb_s3, eh_s3;
	logic signed [ZW-1:0] zr;
	logic signed [16:0] bear, eb_raw;
	logic [35:0]        xs;
	assign zr = z_c + 24'sd128;
	assign bear = sd_c.zero ? '0 : 17'(zr >>> 8);
	assign eb_raw = bear - 17'(sd_c.ryaw);
	assign xs = x_c[CW-1:8];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_c;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			// x times 1/K, upper partial here, lower folded in next stage
			mag_s3 <= sd_c.zero ? '0 : 64'(xs[35:16]) * 64'(gtp_pkg::InvGainQ32);
			if (eb_raw > gtp_pkg::PiQ12) eb_s3 <= eb_raw - gtp_pkg::TwoPiQ12;
			else if (eb_raw < -gtp_pkg::PiQ12) eb_s3 <= eb_raw + gtp_pkg::TwoPiQ12;
			else eb_s3 <= eb_raw;
			eh_s3 <= sd_c.e_head;
		end
	end
	logic [47:0] lo_s3;
	always_ff @(posedge clk) begin
		if (en) lo_s3 <= sd_c.zero ? '0 : 48'(xs[15:0]) * 48'(gtp_pkg::InvGainQ32);
	end

	// stage 4: distance and mode selection
	logic               v_s4;
	logic [1:0]         mode_s4;
	logic [32:0]        dist_s4;
	logic signed [16:0] err_s4;
	logic [15:0]        gain_s4;
	logic [63:0]        dsum;
	logic [47:0]        dist_w;
	logic [16:0]        abs_eb, abs_eh;
	assign dsum = mag_s3 + 64'(lo_s3[47:16]);
	assign dist_w = dsum[63:16];
	assign abs_eb = eb_s3[16] ? 17'(-eb_s3) : 17'(eb_s3);
	assign abs_eh = eh_s3[16] ? 17'(-eh_s3) : 17'(eh_s3);
	logic d_gt, d_lt;
	assign d_gt = dist_w > 48'(arrive_q);
	assign d_lt = dist_w < 48'(arrive_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dist_s4 <= dist_w[32:0];
			if (d_gt && abs_eb > 17'(tol_q)) begin
				mode_s4 <= gtp_pkg::ModeTurnPoint;
				err_s4 <= eb_s3;
				gain_s4 <= bear_gain_q;
			end else if (d_gt && abs_eb < 17'(tol_q)) begin
				mode_s4 <= gtp_pkg::ModeDrive;
				err_s4 <= '0;
				gain_s4 <= dist_gain_q;
			end else if (d_lt && abs_eh > 17'(tol_q)) begin
				mode_s4 <= gtp_pkg::ModeTurnHead;
				err_s4 <= eh_s3;
				gain_s4 <= head_gain_q;
			end else begin
				mode_s4 <= gtp_pkg::ModeStop;
				err_s4 <= '0;
				gain_s4 <= '0;
			end
		end
	end

	// stage 5: gain products
	logic               v_s5;
	logic [1:0]         mode_s5;
	logic [48:0]        sp_s5;
	logic signed [33:0] tp_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s5 <= mode_s4;
			sp_s5 <= (mode_s4 == gtp_pkg::ModeDrive) ?
				49'(dist_s4) * 49'(gain_s4) : '0;
			tp_s5 <= 34'(err_s4) * $signed({1'b0, gain_s4}) + 34'sd2048;
		end
	end

	// stage 6: turn limiting and speed saturation
	logic               v_s6;
	logic [1:0]         mode_s6;
	logic [30:0]        spd_s6;
	logic [21:0]        t_mag;
	logic               t_neg;
	logic signed [21:0] t0;
	logic [21:0]        t1;
	logic [36:0]        sp_sh;
	assign t0 = tp_s5[33:12];
	assign t_neg = t0[21];
	assign t_mag = t_neg ? 22'(-t0) : 22'(t0);
	assign sp_sh = sp_s5[48:12];
	always_comb begin
		t1 = t_mag;
		if (t1 != '0 && t1 < 22'(min_turn_q)) t1 = 22'(min_turn_q);
		if (t1 > 22'(max_turn_q)) t1 = 22'(max_turn_q);
	end
	logic signed [22:0] t_s;
	logic [13:0]        t_fld;
	assign t_s = t_neg ? -$signed({1'b0, t1}) : $signed({1'b0, t1});
	always_comb begin
		if (t_s > 23'sd8191) t_fld = 14'h1FFF;
		else if (t_s < -23'sd8192) t_fld = 14'h2000;
		else t_fld = t_s[13:0];
	end
	logic [13:0] turn_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s6 <= mode_s5;
			spd_s6 <= (sp_sh > 37'h7FFFFFFF) ? 31'h7FFFFFFF : sp_sh[30:0];
			turn_s6 <= t_fld;
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata = {1'b0, mode_s6, turn_s6, spd_s6};

	// checks
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output word changed while stalled");
	a_drive_noturn: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[46:45] == gtp_pkg::ModeDrive ||
		m_axis_tdata[46:45] == gtp_pkg::ModeStop) |-> m_axis_tdata[44:31] == '0)
		else $error("turn in drive or stop mode");
	a_turn_nospeed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[46:45] != gtp_pkg::ModeDrive
		|-> m_axis_tdata[30:0] == '0)
		else $error("speed outside drive mode");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready does not follow output stall");
endmodule
`default_nettype wire

[verif/go_to_pose_velocity_controller_test.sv]
// go_to_pose_velocity_controller_test: self-checking bench for the go-to-pose controller
// drives pose words and apb register writes, predicts each output word; needs gtp_pkg
`default_nettype none
module go_to_pose_velocity_controller_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [14:0] ryaw;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [14:0] tyaw;
	} pose_t;

	typedef struct packed {
		logic [30:0]        speed;
		logic signed [13:0] turn;
		logic [1:0]         mode;
	} cmd_t;

	typedef struct packed {
		pose_t p;
		logic  typed;
		cmd_t  c;
	} row_t;

	localparam int WatchLimit = 20000;
	localparam int Latency = gtp_pkg::CordicStages + 6;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// robot_x, robot_y, robot_yaw, target_x, target_y, target_yaw, zero pad
	logic [159:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// linear_speed, turn_rate, mode, zero pad
	logic [47:0]  m_axis_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	go_to_pose_velocity_controller u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow registers and expected output words
	longint unsigned ctl [7];
	cmd_t            cmd_q [$];
	int              errors = 0;
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	bit              hold_req = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint wrap_pi(input longint e);
		if (e > 12868) e -= 25736;
		if (e < -12868) e += 25736;
		return e;
	endfunction

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// vectoring cordic, mode choice, gains and limits
	function automatic cmd_t steer(input pose_t p);
		longint angles [16] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
			8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
		longint dx, dy, x, y, z, nx, ny, bearing, e_head, e_bear, turn;
		longint unsigned xs, goal_dist, speed;
		cmd_t c;
		dx = longint'(p.tx) - longint'(p.rx);
		dy = longint'(p.ty) - longint'(p.ry);
		turn = 0;
		speed = 0;
		if (dx == 0 && dy == 0) begin
			bearing = 0;
			goal_dist = 0;
		end else begin
			x = dx * 256;
			y = dy * 256;
			z = 0;
			if (x < 0) begin
				z = (y >= 0) ? 3294199 : -3294199;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < 16; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z += angles[i];
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z -= angles[i];
				end
				x = nx;
				y = ny;
			end
			bearing = (z + 128) >>> 8;
			xs = longint'(unsigned'(x)) >> 8;
			goal_dist = ((xs >> 16) * 64'd2608131496 +
				(((xs & 64'hFFFF) * 64'd2608131496) >> 16)) >> 16;
		end
		e_head = wrap_pi(longint'(p.tyaw) - longint'(p.ryaw));
		e_bear = wrap_pi(bearing - longint'(p.ryaw));
		if (goal_dist > ctl[gtp_pkg::RegArrive] &&
				mag(e_bear) > longint'(ctl[gtp_pkg::RegAngTol])) begin
			c.mode = gtp_pkg::ModeTurnPoint;
			turn = (longint'(ctl[gtp_pkg::RegBearGain]) * e_bear + 2048) >>> 12;
		end else if (goal_dist > ctl[gtp_pkg::RegArrive] &&
				mag(e_bear) < longint'(ctl[gtp_pkg::RegAngTol])) begin
			c.mode = gtp_pkg::ModeDrive;
			speed = (ctl[gtp_pkg::RegDistGain] * goal_dist) >> 12;
			if (speed > 64'd2147483647) speed = 64'd2147483647;
		end else if (goal_dist < ctl[gtp_pkg::RegArrive] &&
				mag(e_head) > longint'(ctl[gtp_pkg::RegAngTol])) begin
			c.mode = gtp_pkg::ModeTurnHead;
			turn = (longint'(ctl[gtp_pkg::RegHeadGain]) * e_head + 2048) >>> 12;
		end else begin
			c.mode = gtp_pkg::ModeStop;
		end
		if (turn != 0 && mag(turn) < longint'(ctl[gtp_pkg::RegMinTurn]))
			turn = turn < 0 ? -longint'(ctl[gtp_pkg::RegMinTurn]) :
				longint'(ctl[gtp_pkg::RegMinTurn]);
		if (mag(turn) > longint'(ctl[gtp_pkg::RegMaxTurn]))
			turn = turn < 0 ? -longint'(ctl[gtp_pkg::RegMaxTurn]) :
				longint'(ctl[gtp_pkg::RegMaxTurn]);
		if (turn > 8191) turn = 8191;
		if (turn < -8192) turn = -8192;
		c.speed = speed[30:0];
		c.turn = turn[13:0];
		return c;
	endfunction

	// register write, setup then access cycle
	task automatic reg_write(input logic [2:0] idx, input longint unsigned val);
		longint unsigned masks [7] = '{64'hFFFF, 64'hFFFF, 64'hFFFF, 64'h7FFFFFFF,
			64'h7FFF, 64'h7FFF, 64'h7FFF};
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val[31:0];
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		ctl[idx] = val[31:0] & masks[idx];
	endtask

	// offer one pose word, keep valid up until it is taken
	task automatic send(input pose_t p, input logic typed, input cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, p.tyaw, p.ty, p.tx, p.ryaw, p.ry, p.rx};
		do @(posedge clk); while (!s_axis_tready);
		cmd_q.push_back(typed ? c : steer(p));
		@(negedge clk);
	endtask

	function automatic logic signed [14:0] any_yaw();
		if ($urandom_range(9) == 0) return 15'($urandom);
		return 15'(int'($urandom_range(25736)) - 12868);
	endfunction

	// random pose pair, mostly near goal distances, some headings aligned with the goal
	function automatic pose_t rand_pose();
		pose_t p;
		int span;
		p.rx = $urandom;
		p.ry = $urandom;
		p.ryaw = any_yaw();
		p.tyaw = any_yaw();
		span = $urandom_range(24, 4);
		p.tx = p.rx + ($signed($urandom) >>> (32 - span));
		p.ty = p.ry + ($signed($urandom) >>> (32 - span));
		case ($urandom_range(7))
			0: begin
				p.tx = $urandom;
				p.ty = $urandom;
			end
			1: begin
				p.tx = p.rx + ($signed($urandom) >>> 17);
				p.ty = p.ry + ($signed($urandom) >>> 17);
			end
			2: begin
				p.tx = p.rx;
				p.ty = p.ry;
			end
			3, 4: begin
				// roughly facing the goal along +x
				p.tx = p.rx + $urandom_range(32'h7FFFFF, 1);
				p.ty = p.ry + ($signed($urandom) >>> 26);
				p.ryaw = 15'(int'($urandom_range(1600)) - 800);
			end
			default: ;
		endcase
		return p;
	endfunction

	// receiver with random stalls and one long hold-off
	initial begin
		int hold;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				for (hold = 0; hold < 300; hold++) @(negedge clk);
				hold_req = 0;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// output checker
	initial begin
		cmd_t want;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (cmd_q.size() == 0) begin
					$display("unexpected output word at %0t", $realtime);
					errors++;
				end else begin
					want = cmd_q.pop_front();
					if (m_axis_tdata[30:0] !== want.speed)
						report("linear_speed", m_axis_tdata[30:0], want.speed);
					if ($signed(m_axis_tdata[44:31]) !== want.turn)
						report("turn_rate", $signed(m_axis_tdata[44:31]), want.turn);
					if (m_axis_tdata[46:45] !== want.mode)
						report("mode", m_axis_tdata[46:45], want.mode);
				end
			end
		end
	end

	// watchdog on cycles with no word moving and no register access
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
				quiet = 0;
			else
				quiet++;
			if (quiet >= WatchLimit) begin
				$display("go_to_pose_velocity_controller_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		row_t rows [12];
		cmd_t none;
		logic [2:0] idx;
		int n;
		none = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		ctl = '{2048, 410, 2048, 22938, 819, 2458, 4915};

		// directed rows: coincident points, wraps, min turn, extremes, off-range yaw
		rows[0] = '{'{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, gtp_pkg::ModeStop}};
		rows[1] = '{'{5, 7, -15'sd12868, 5, 7, 15'sd12868}, 1'b1,
			'{0, 0, gtp_pkg::ModeStop}};
		rows[2] = '{'{0, 0, 0, 0, 0, 15'sd1000}, 1'b1,
			'{0, 14'sd2458, gtp_pkg::ModeTurnHead}};
		rows[3] = '{'{0, 0, 0, 0, 0, -15'sd1000}, 1'b1,
			'{0, -14'sd2458, gtp_pkg::ModeTurnHead}};
		rows[4] = '{'{32'sh80000000, 32'sh80000000, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0},
			1'b0, none};
		rows[5] = '{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 15'sh3FFF, 32'sh80000000,
			32'sh80000000, 15'sh4000}, 1'b0, none};
		rows[6] = '{'{0, 0, 0, 32'sh00100000, 0, 0}, 1'b0, none};
		rows[7] = '{'{0, 0, 0, -32'sh00100000, 0, 0}, 1'b0, none};
		rows[8] = '{'{0, 0, 0, -32'sh00100000, -1, 0}, 1'b0, none};
		rows[9] = '{'{0, 0, 15'sd6434, 0, 32'sh00100000, 0}, 1'b0, none};
		rows[10] = '{'{0, 0, 0, 22938, 0, 15'sd900}, 1'b0, none};
		rows[11] = '{'{0, 0, 15'sh4000, 0, 0, 15'sh3FFF}, 1'b0, none};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) send(rows[i].p, rows[i].typed, rows[i].c);
		// long hold-off while the sender keeps offering
		hold_req = 1;
		for (n = 0; n < 60; n++) send(rand_pose(), 1'b0, none);

		for (int phase = 0; phase < 6; phase++) begin
			send_idle_pct = (phase % 4 == 1) ? 66 : (phase % 4 == 3) ? 23 : 0;
			recv_stall_pct = (phase % 4 == 2) ? 66 : (phase % 4 == 3) ? 23 : 0;
			for (n = 0; n < 215; n++) send(rand_pose(), 1'b0, none);
			s_axis_tvalid <= 1'b0;
			while (cmd_q.size() != 0) @(negedge clk);
			repeat (Latency + 4) @(negedge clk);
			// next register setting: random, all ones, all zeros, min above max, bounded random, random
			for (int r = 0; r < 7; r++) begin
				idx = 3'(r);
				case (phase)
					0: reg_write(idx, $urandom);
					1: reg_write(idx, 64'hFFFFFFFF);
					2: reg_write(idx, 0);
					3: reg_write(idx, (idx == gtp_pkg::RegMinTurn) ? 5000 :
						(idx == gtp_pkg::RegMaxTurn) ? 3000 : $urandom_range(8000, 100));
					4: reg_write(idx, (idx == gtp_pkg::RegArrive) ? $urandom_range(32'h7FFFF) :
						(idx == gtp_pkg::RegAngTol) ? $urandom_range(2000) :
						$urandom_range(16384));
					default: reg_write(idx, $urandom);
				endcase
			end
		end
		for (n = 0; n < 40; n++) send(rand_pose(), 1'b0, none);
		s_axis_tvalid <= 1'b0;

		while (cmd_q.size() != 0) @(negedge clk);
		repeat (Latency + 10) @(negedge clk);
		if (errors == 0) begin
			$display("go_to_pose_velocity_controller_test: PASS");
		end else begin
			$display("go_to_pose_velocity_controller_test: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
